// ===== rtl/core/sgm_pkg.sv =====
// Package for the SCCP global-title match block: payload types, codes and defaults.
package sgm_pkg;

    // Default limits, handed to the top level's parameters
    localparam int MAX_DIGITS_DEF  = 31;
    localparam int MAX_PATTERN_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_DIGITS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_SSN        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNCONDITIONAL  = 4'd3;

    // Nibble codes
    localparam logic [3:0] NIB_FILLER = 4'hf;
    localparam logic [3:0] SYM_WILD   = 4'ha;   // '?'
    localparam logic [3:0] SYM_STAR   = 4'hb;   // '*'
    localparam logic [3:0] SYM_HASH   = 4'hc;   // '#'

    // Decision status
    typedef enum logic [2:0] {
        ST_MATCH      = 3'd0,
        ST_NO_MATCH   = 3'd1,
        ST_SSN_ABSENT = 3'd2,
        ST_TOO_SHORT  = 3'd3,
        ST_TOO_MANY   = 3'd4
    } status_t;

    // One address byte
    typedef struct packed {
        logic [7:0] addr_byte;
        logic       last;
    } item_t;

    // One rewrite decision
    typedef struct packed {
        logic       rewrite;
        logic [1:0] ssn_offset;
        logic [7:0] replacement_ssn;
        logic [4:0] digit_count;
        status_t    status;
    } result_t;

endpackage

// ===== rtl/core/sccp_gt_match_ssn_rewrite.sv =====
// SCCP called-party address global-title match with SSN rewrite decision.
// Throughput: one address byte per cycle unless item_stall, both BCD nibbles of a digit byte in that cycle.
// The decision is registered: into the result register, or into the skid entry while that one is held.
// The cycle is set by the two chained nibble compares against the pattern select.
// A two-entry output (result register plus skid) keeps input flowing while a result waits.
// Reset (rst_n, asynchronous, active low) clears config registers, parser state and output valid flags.
module sccp_gt_match_ssn_rewrite #(
    parameter int MAX_DIGITS  = sgm_pkg::MAX_DIGITS_DEF,
    parameter int MAX_PATTERN = sgm_pkg::MAX_PATTERN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  sgm_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output sgm_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sgm_pkg::*;

    localparam int DSW = $clog2(MAX_DIGITS + 2);

    // Digit-phase state that one nibble updates
    typedef struct packed {
        logic [DSW-1:0] seen;
        logic [5:0]     dcount;
        logic           filler;
        logic           mismatch;
    } nst_t;

    // Configuration registers
    logic [63:0] pattern_reg;
    logic [4:0]  plen_cfg_reg;
    logic [7:0]  new_ssn_reg;
    logic        uncond_reg;

    // Parser state
    logic [2:0] header_pos_reg, header_pos_next;
    logic [1:0] ind_reg, ind_next;
    logic       odd_reg, odd_next;
    logic       phase_reg, phase_next;
    nst_t       nst_reg, nst_next;

    // Output stage
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic       item_acc, out_fire, res_new;
    logic [2:0] tt_pos;
    logic       too_short;
    logic [4:0] plen_eff, plen_clamp;
    logic       plen_found;
    nst_t       nst_a, nst_b;
    result_t    res_calc;
    status_t    status_calc;

    function automatic logic [3:0] map_symbol(input logic [3:0] nib);
        if (nib inside {[4'd0:4'd9], SYM_STAR, SYM_HASH, NIB_FILLER})
            return nib;
        return SYM_WILD;
    endfunction

    function automatic nst_t take_nibble(input nst_t s, input logic [3:0] nib,
                                         input logic [4:0] plen, input logic [63:0] pat);
        nst_t       r;
        logic [3:0] psym;
        r    = s;
        psym = pat[{s.dcount[3:0], 2'b00} +: 4];
        if (s.seen <= DSW'(MAX_DIGITS))
            r.seen = s.seen + 1'b1;
        if (!s.filler)
        begin
            if (nib == NIB_FILLER)
                r.filler = 1'b1;
            else
            begin
                if (s.dcount >= {1'b0, plen} || map_symbol(nib) != map_symbol(psym))
                    r.mismatch = 1'b1;
                if (s.dcount != 6'd63)
                    r.dcount = s.dcount + 6'd1;
            end
        end
        return r;
    endfunction

    assign cfg_ready  = 1'b1;
    assign item_stall = skid_valid_reg;
    assign item_acc   = item_valid && !skid_valid_reg;
    assign out_fire   = out_valid_reg && !result_stall;
    assign res_new    = item_acc && item.last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            plen_cfg_reg <= '0;
            new_ssn_reg  <= '0;
            uncond_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_DIGITS: pattern_reg  <= cfg_data;
                REG_PATTERN_LENGTH: plen_cfg_reg <= cfg_data[4:0];
                REG_NEW_SSN:        new_ssn_reg  <= cfg_data[7:0];
                REG_UNCONDITIONAL:  uncond_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective pattern length: clamped length, cut at the first filler symbol
    always_comb
    begin
        plen_clamp = (plen_cfg_reg > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : plen_cfg_reg;
        plen_eff   = plen_clamp;
        plen_found = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            if (!plen_found && 5'(k) < plen_clamp && pattern_reg[k*4 +: 4] == NIB_FILLER)
            begin
                plen_eff   = 5'(k);
                plen_found = 1'b1;
            end
        end
    end

    // Header walk and digit decode for the current byte
    always_comb
    begin
        header_pos_next = header_pos_reg;
        ind_next        = ind_reg;
        odd_next        = odd_reg;
        phase_next      = phase_reg;
        tt_pos          = 3'd0;
        too_short       = 1'b0;
        nst_a           = nst_reg;
        nst_b           = nst_reg;
        if (!phase_reg)
        begin
            if (header_pos_reg == 3'd0)
                ind_next = item.addr_byte[1:0];
            tt_pos = 3'd1 + {1'b0, ind_next[0], 1'b0} + {2'b00, ind_next[1]};
            if (header_pos_reg == tt_pos + 3'd1)
                odd_next = item.addr_byte[0];
            if (header_pos_reg == tt_pos + 3'd2)
            begin
                phase_next = 1'b1;
                if (item.last && odd_reg)
                    too_short = 1'b1;
            end
            else if (item.last)
                too_short = 1'b1;
            header_pos_next = header_pos_reg + 3'd1;
        end
        else
        begin
            // low nibble first; the final high nibble is dropped on an odd address
            nst_a = take_nibble(nst_reg, item.addr_byte[3:0], plen_eff, pattern_reg);
            nst_b = nst_a;
            if (!(item.last && odd_reg))
                nst_b = take_nibble(nst_a, item.addr_byte[7:4], plen_eff, pattern_reg);
        end
        nst_next = nst_b;
    end

    // Decision for a last byte
    always_comb
    begin
        if (too_short)
            status_calc = ST_TOO_SHORT;
        else if (nst_next.seen > DSW'(MAX_DIGITS))
            status_calc = ST_TOO_MANY;
        else if (!ind_next[1])
            status_calc = ST_SSN_ABSENT;
        else if (uncond_reg)
            status_calc = ST_MATCH;
        else if (!nst_next.mismatch && nst_next.dcount == {1'b0, plen_eff})
            status_calc = ST_MATCH;
        else
            status_calc = ST_NO_MATCH;

        res_calc.rewrite         = (status_calc == ST_MATCH);
        res_calc.ssn_offset      = ind_next[1] ? {ind_next[0], 1'b1} : 2'd0;
        res_calc.replacement_ssn = new_ssn_reg;
        res_calc.digit_count     = (nst_next.dcount > 6'd31) ? 5'd31 : nst_next.dcount[4:0];
        res_calc.status          = status_calc;
    end

    // Parser state registers; cleared after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg <= '0;
            ind_reg        <= '0;
            odd_reg        <= 1'b0;
            phase_reg      <= 1'b0;
            nst_reg        <= '0;
        end
        else if (item_acc)
        begin
            if (item.last)
            begin
                header_pos_reg <= '0;
                ind_reg        <= '0;
                odd_reg        <= 1'b0;
                phase_reg      <= 1'b0;
                nst_reg        <= '0;
            end
            else
            begin
                header_pos_reg <= header_pos_next;
                ind_reg        <= ind_next;
                odd_reg        <= odd_next;
                phase_reg      <= phase_next;
                nst_reg        <= nst_next;
            end
        end
    end

    // Output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (res_new)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (res_new)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= res_calc;
            else
                out_reg <= res_calc;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_rewrite_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.rewrite == (out_reg.status == ST_MATCH)))
        else $error("rewrite flag disagrees with status");

    a_absent_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_SSN_ABSENT) |-> (out_reg.ssn_offset == 2'd0))
        else $error("offset given for an absent SSN");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_new |=> (header_pos_reg == 3'd0 && !phase_reg && nst_reg == '0))
        else $error("parser state not cleared after last byte");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_new |=> out_valid_reg)
        else $error("accepted last byte produced no result");

endmodule
